// ===== hdl/quaternion_to_rotation_matrix_top_macros.svh =====
// assertion macros used by the quaternion to rotation matrix top level
`ifndef QUATERNION_TO_ROTATION_MATRIX_TOP_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_TOP_MACROS_SVH
`ifndef SYNTHESIS
// property checked outside reset
`define QRM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("qrm assertion failed");
// property checked at every edge, reset included
`define QRM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("qrm assertion failed");
`else
`define QRM_ASSERT(lbl, clk, rstn, prop)
`define QRM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hdl/qrm_pkg.sv =====
// shared widths and types of the quaternion to rotation matrix pipeline
`default_nettype none
package qrm_pkg;
  localparam int unsigned COMP_W        = 16;
  localparam int unsigned FRAC_BITS_DEF = 14;
  localparam int unsigned NUM_ENT       = 9;
  localparam int unsigned NUM_PROD      = 10;
  localparam int unsigned PROD_W        = 32;
  localparam int unsigned NORM_W        = 33;
  localparam int unsigned SNUM_W        = 34;
  localparam int unsigned REM_W         = 32;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [REM_W-1:0]         rem_t;
  typedef logic [NORM_W-1:0]        norm_t;

  // per item side info riding along the divider
  typedef struct packed {
    logic [NUM_ENT-1:0] neg;
    logic               degen;
  } side_t;
endpackage
`default_nettype wire

// ===== hdl/qrm_front.sv =====
// products, norm and numerators, magnitudes: three register stages
`default_nettype none
module qrm_front
  import qrm_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire comp_t [3:0]               quat_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output rem_t [NUM_ENT-1:0]             out_rem_o,
  output logic [NUM_ENT-1:0]             out_qint_o,
  output norm_t                          out_norm_o,
  output side_t                          out_side_o
);
  localparam int unsigned PXX = 0, PYY = 1, PZZ = 2, PWW = 3, PXY = 4;
  localparam int unsigned PXZ = 5, PYZ = 6, PWX = 7, PWY = 8, PWZ = 9;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic signed [PROD_W-1:0] prod_d [NUM_PROD];
  logic signed [PROD_W-1:0] prod_q [NUM_PROD];
  norm_t                    norm_d, norm2_q, norm3_q;
  logic signed [SNUM_W-1:0] num_d [NUM_ENT];
  logic signed [SNUM_W-1:0] num_q [NUM_ENT];
  logic                     degen2_q;
  rem_t [NUM_ENT-1:0]       rem_d, rem_q;
  logic [NUM_ENT-1:0]       qint_d, qint_q;
  side_t                    side_d, side_q;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    comp_t x, y, z, w;
    x = quat_i[0];
    y = quat_i[1];
    z = quat_i[2];
    w = quat_i[3];
    prod_d[PXX] = x * x;
    prod_d[PYY] = y * y;
    prod_d[PZZ] = z * z;
    prod_d[PWW] = w * w;
    prod_d[PXY] = x * y;
    prod_d[PXZ] = x * z;
    prod_d[PYZ] = y * z;
    prod_d[PWX] = w * x;
    prod_d[PWY] = w * y;
    prod_d[PWZ] = w * z;
  end

  // norm and the nine numerators, each bounded by the norm in magnitude
  always_comb begin
    logic signed [SNUM_W-1:0] p [NUM_PROD];
    logic signed [SNUM_W-1:0] ns;
    for (int i = 0; i < NUM_PROD; i++) begin
      p[i] = SNUM_W'(prod_q[i]);
    end
    ns        = p[PXX] + p[PYY] + p[PZZ] + p[PWW];
    norm_d    = ns[NORM_W-1:0];
    num_d[0]  = ns - ((p[PYY] + p[PZZ]) <<< 1);
    num_d[1]  = (p[PXY] - p[PWZ]) <<< 1;
    num_d[2]  = (p[PXZ] + p[PWY]) <<< 1;
    num_d[3]  = (p[PXY] + p[PWZ]) <<< 1;
    num_d[4]  = ns - ((p[PXX] + p[PZZ]) <<< 1);
    num_d[5]  = (p[PYZ] - p[PWX]) <<< 1;
    num_d[6]  = (p[PXZ] - p[PWY]) <<< 1;
    num_d[7]  = (p[PYZ] + p[PWX]) <<< 1;
    num_d[8]  = ns - ((p[PXX] + p[PYY]) <<< 1);
  end

  // sign and magnitude, integer quotient bit taken here since mag <= norm
  always_comb begin
    logic [SNUM_W-1:0] mag;
    for (int e = 0; e < NUM_ENT; e++) begin
      mag            = num_q[e][SNUM_W-1] ? SNUM_W'(-num_q[e]) : SNUM_W'(num_q[e]);
      side_d.neg[e]  = num_q[e][SNUM_W-1];
      qint_d[e]      = (mag == SNUM_W'(norm2_q));
      rem_d[e]       = qint_d[e] ? '0 : mag[REM_W-1:0];
    end
    side_d.degen = degen2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      prod_q <= prod_d;
    end
    if (rdy2 && v1_q) begin
      num_q    <= num_d;
      norm2_q  <= norm_d;
      degen2_q <= (norm_d == '0);
    end
    if (rdy3 && v2_q) begin
      rem_q   <= rem_d;
      qint_q  <= qint_d;
      norm3_q <= norm2_q;
      side_q  <= side_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_rem_o   = rem_q;
  assign out_qint_o  = qint_q;
  assign out_norm_o  = norm3_q;
  assign out_side_o  = side_q;
endmodule
`default_nettype wire

// ===== hdl/qrm_dstep.sv =====
// one restoring division step for all nine entries
`default_nettype none
module qrm_dstep
  import qrm_pkg::*;
#(
  parameter int unsigned QW = FRAC_BITS_DEF + 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire rem_t [NUM_ENT-1:0]            in_rem_i,
  input  wire logic [NUM_ENT-1:0][QW-1:0]    in_q_i,
  input  wire norm_t                         in_norm_i,
  input  wire side_t                         in_side_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output rem_t [NUM_ENT-1:0]                 out_rem_o,
  output logic [NUM_ENT-1:0][QW-1:0]         out_q_o,
  output norm_t                              out_norm_o,
  output side_t                              out_side_o
);
  logic                        valid_q, rdy;
  rem_t [NUM_ENT-1:0]          rem_d, rem_q;
  logic [NUM_ENT-1:0][QW-1:0]  q_d, q_q;
  norm_t                       norm_q;
  side_t                       side_q;

  assign rdy        = !valid_q || out_ready_i;
  assign in_ready_o = rdy;

  always_comb begin
    logic [NORM_W-1:0] r2;
    logic              ge;
    for (int e = 0; e < NUM_ENT; e++) begin
      r2       = {in_rem_i[e], 1'b0};
      ge       = (r2 >= in_norm_i);
      rem_d[e] = ge ? REM_W'(r2 - in_norm_i) : REM_W'(r2);
      q_d[e]   = {in_q_i[e][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      rem_q  <= rem_d;
      q_q    <= q_d;
      norm_q <= in_norm_i;
      side_q <= in_side_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rem_o   = rem_q;
  assign out_q_o     = q_q;
  assign out_norm_o  = norm_q;
  assign out_side_o  = side_q;
endmodule
`default_nettype wire

// ===== hdl/qrm_out.sv =====
// final rounding, sign, identity override and output register
`default_nettype none
module qrm_out
  import qrm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [NUM_ENT-1:0][FRAC_BITS+1:0]   in_q_i,
  input  wire side_t                               in_side_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output comp_t [NUM_ENT-1:0]                      out_ent_o,
  output logic                                     out_degen_o
);
  localparam int unsigned QW = FRAC_BITS + 2;
  localparam int unsigned EW = (QW + 1 > COMP_W) ? QW + 1 : COMP_W;
  localparam logic [EW-1:0] ONE_EXT = EW'(1) << FRAC_BITS;

  logic                 valid_q, rdy;
  comp_t [NUM_ENT-1:0]  ent_d, ent_q;
  logic                 degen_q;

  assign rdy        = !valid_q || out_ready_i;
  assign in_ready_o = rdy;

  // quotient holds F+1 fraction bits; add half and drop one for nearest rounding
  always_comb begin
    logic [QW:0]   rnd;
    logic [EW-1:0] mag, sv;
    for (int e = 0; e < NUM_ENT; e++) begin
      rnd = ({1'b0, in_q_i[e]} + (QW+1)'(1)) >> 1;
      mag = EW'(rnd);
      sv  = in_side_i.neg[e] ? (~mag + EW'(1)) : mag;
      if (in_side_i.degen) begin
        sv = ((e % 4) == 0) ? ONE_EXT : '0;
      end
      ent_d[e] = sv[COMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      ent_q   <= ent_d;
      degen_q <= in_side_i.degen;
    end
  end

  assign out_valid_o = valid_q;
  assign out_ent_o   = ent_q;
  assign out_degen_o = degen_q;
endmodule
`default_nettype wire

// ===== hdl/quaternion_to_rotation_matrix_top.sv =====
// top level of the quaternion to rotation matrix pipeline
//
//  channel   direction  tdata                                  tuser
//  s_axis    in         quat_x, quat_y, quat_z, quat_w (64b)   none
//  m_axis    out        m_row0_col0 .. m_row2_col2 (144b)      degenerate
//
// one quaternion per cycle sustained while m_axis is ready; the divider
// is bit-per-stage with F+1 steps
// each stage holds its item until the next stage frees up, so a stall
// on m_axis backs up stage by stage and drops or repeats nothing
// reset clears only the valid bits; the payload registers are not reset
`default_nettype none
`include "quaternion_to_rotation_matrix_top_macros.svh"
module quaternion_to_rotation_matrix_top
  import qrm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // quat_x, quat_y, quat_z, quat_w from bit 0 up
  input  wire logic [63:0]   s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  // m_row0_col0 .. m_row2_col2 from bit 0 up, 16 bits each
  output logic [143:0]       m_axis_tdata_o,
  // degenerate
  output logic               m_axis_tuser_o
);
  localparam int unsigned QW    = FRAC_BITS + 2;
  localparam int unsigned NSTEP = FRAC_BITS + 1;
  localparam logic [COMP_W-1:0] ONE_ENC = COMP_W'(64'd1 << FRAC_BITS);

  comp_t [3:0]                 quat;
  logic [NSTEP:0]              c_valid, c_ready;
  rem_t [NUM_ENT-1:0]          c_rem  [NSTEP+1];
  logic [NUM_ENT-1:0][QW-1:0]  c_q    [NSTEP+1];
  norm_t                       c_norm [NSTEP+1];
  side_t                       c_side [NSTEP+1];
  logic [NUM_ENT-1:0]          qint;
  comp_t [NUM_ENT-1:0]         ent;
  logic                        out_ready;

  // unpack components from the transfer
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      quat[i] = s_axis_tdata_i[i*COMP_W +: COMP_W];
    end
  end

  qrm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .quat_i      (quat),
    .out_valid_o (c_valid[0]),
    .out_ready_i (c_ready[0]),
    .out_rem_o   (c_rem[0]),
    .out_qint_o  (qint),
    .out_norm_o  (c_norm[0]),
    .out_side_o  (c_side[0])
  );

  // integer quotient bit seeds the running quotient
  always_comb begin
    for (int e = 0; e < NUM_ENT; e++) begin
      c_q[0][e] = QW'(qint[e]);
    end
  end

  for (genvar s = 0; s < NSTEP; s++) begin : g_div
    qrm_dstep #(.QW(QW)) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (c_valid[s]),
      .in_ready_o  (c_ready[s]),
      .in_rem_i    (c_rem[s]),
      .in_q_i      (c_q[s]),
      .in_norm_i   (c_norm[s]),
      .in_side_i   (c_side[s]),
      .out_valid_o (c_valid[s+1]),
      .out_ready_i (c_ready[s+1]),
      .out_rem_o   (c_rem[s+1]),
      .out_q_o     (c_q[s+1]),
      .out_norm_o  (c_norm[s+1]),
      .out_side_o  (c_side[s+1])
    );
  end

  qrm_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (c_valid[NSTEP]),
    .in_ready_o  (out_ready),
    .in_q_i      (c_q[NSTEP]),
    .in_side_i   (c_side[NSTEP]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_ent_o   (ent),
    .out_degen_o (m_axis_tuser_o)
  );
  assign c_ready[NSTEP] = out_ready;

  assign m_axis_tdata_o = ent;

  // empty output register means every stage can move
  `QRM_ASSERT(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid_o |-> s_axis_tready_o)
  // zero quaternion gives the identity diagonal
  `QRM_ASSERT(a_degen_diag, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[15:0] == ONE_ENC && m_axis_tdata_o[79:64] == ONE_ENC && m_axis_tdata_o[143:128] == ONE_ENC))
  // and zero off the diagonal
  `QRM_ASSERT(a_degen_off, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[63:16] == '0 && m_axis_tdata_o[127:80] == '0))
  // nothing leaves the pipeline right after reset
  `QRM_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid_o)
endmodule
`default_nettype wire
